// ===== src/assert_macros.svh =====
// Assertion helpers for the file that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPLY(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

`endif

// ===== src/e2utc_pkg.sv =====
package e2utc_pkg;

  // Reciprocals floor(2^k / d) for estimate-and-correct division by constants.
  localparam logic [26:0] RECIP_15_HI = 27'd71582788;  // k = 30
  localparam logic [21:0] RECIP_15_LO = 22'd2236962;   // k = 25
  localparam logic [16:0] RECIP_3     = 17'd87381;     // k = 18
  localparam logic [13:0] RECIP_7     = 14'd9362;      // k = 16
  localparam logic [5:0]  RECIP_1461  = 6'd44;         // k = 16

  localparam logic [10:0] DAYS_PER_QUAD  = 11'd1461;
  localparam logic [9:0]  DAYS_1968_1970 = 10'd731;
  localparam logic [7:0]  BASE_YEAR      = 8'd68;
  localparam logic [8:0]  DAYS_LEAP_YEAR = 9'd366;
  localparam logic [8:0]  DAYS_YEAR      = 9'd365;
  localparam logic [2:0]  EPOCH_WEEKDAY  = 3'd4;
  localparam logic [31:0] LIMIT_2100     = 32'd4102444800;

  typedef struct packed {
    logic        valid;
    logic [15:0] days;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic        in_range;
  } tod_t;

  typedef struct packed {
    logic       valid;
    logic [5:0] second;
    logic [5:0] minute;
    logic [4:0] hour;
    logic [2:0] weekday;
    logic [4:0] day_of_month;
    logic [3:0] month;
    logic [7:0] years_since_1900;
    logic       in_range;
  } date_t;

  // Day of year on which a month begins, counted from zero.
  function automatic logic [8:0] month_start(input logic leap, input logic [3:0] idx);
    logic [8:0] base;
    base = 9'd0;
    unique case (idx)
      4'd0:    base = 9'd0;
      4'd1:    base = 9'd31;
      4'd2:    base = 9'd59;
      4'd3:    base = 9'd90;
      4'd4:    base = 9'd120;
      4'd5:    base = 9'd151;
      4'd6:    base = 9'd181;
      4'd7:    base = 9'd212;
      4'd8:    base = 9'd243;
      4'd9:    base = 9'd273;
      4'd10:   base = 9'd304;
      4'd11:   base = 9'd334;
      default: base = 9'd0;
    endcase
    if (leap && (idx >= 4'd2)) begin
      base = base + 9'd1;
    end
    return base;
  endfunction

endpackage

// ===== src/e2utc_tod.sv =====
module e2utc_tod (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [31:0]        epoch,
  output e2utc_pkg::tod_t    tod
);

  // Stage 1: estimate of (t / 4) / 15.
  logic        v1_r;
  logic [56:0] p1_r;
  logic [4:0]  xlo1_r;
  logic [1:0]  lo1_r;
  logic        rng1_r;

  // Stage 2: minutes since epoch and second.
  logic        v2_r;
  logic [26:0] q1_r;
  logic [5:0]  sec2_r;
  logic        rng2_r;

  // Stage 3: estimate of (minutes / 4) / 15.
  logic        v3_r;
  logic [46:0] p2_r;
  logic [4:0]  xlo3_r;
  logic [1:0]  lo3_r;
  logic [5:0]  sec3_r;
  logic        rng3_r;

  // Stage 4: hours since epoch and minute.
  logic        v4_r;
  logic [20:0] q2_r;
  logic [5:0]  min4_r;
  logic [5:0]  sec4_r;
  logic        rng4_r;

  // Stage 5: estimate of (hours / 8) / 3.
  logic        v5_r;
  logic [34:0] p3_r;
  logic [2:0]  xlo5_r;
  logic [2:0]  lo5_r;
  logic [5:0]  min5_r;
  logic [5:0]  sec5_r;
  logic        rng5_r;

  // Stage 6: days since epoch and hour.
  logic        v6_r;
  logic [15:0] days6_r;
  logic [4:0]  hr6_r;
  logic [5:0]  min6_r;
  logic [5:0]  sec6_r;
  logic        rng6_r;

  logic [56:0] p1_nxt;
  logic [26:0] q1_est;
  logic [30:0] q1_x15;
  logic [4:0]  r1;
  logic [26:0] q1_nxt;
  logic [5:0]  sec2_nxt;
  logic [46:0] p2_nxt;
  logic [20:0] q2_est;
  logic [25:0] q2_x15;
  logic [4:0]  r2;
  logic [20:0] q2_nxt;
  logic [5:0]  min4_nxt;
  logic [34:0] p3_nxt;
  logic [15:0] q3_est;
  logic [17:0] q3_x3;
  logic [2:0]  r3;
  logic [15:0] days6_nxt;
  logic [4:0]  hr6_nxt;

  always_comb begin
    p1_nxt = {27'd0, epoch[31:2]} * {30'd0, e2utc_pkg::RECIP_15_HI};

    q1_est = p1_r[56:30];
    q1_x15 = {q1_est, 4'd0} - {4'd0, q1_est};
    r1     = xlo1_r - q1_x15[4:0];
    if (r1 >= 5'd15) begin
      q1_nxt   = q1_est + 27'd1;
      sec2_nxt = {4'(r1 - 5'd15), lo1_r};
    end else begin
      q1_nxt   = q1_est;
      sec2_nxt = {r1[3:0], lo1_r};
    end

    p2_nxt = {22'd0, q1_r[26:2]} * {25'd0, e2utc_pkg::RECIP_15_LO};

    q2_est = p2_r[45:25];
    q2_x15 = {1'b0, q2_est, 4'd0} - {5'd0, q2_est};
    r2     = xlo3_r - q2_x15[4:0];
    if (r2 >= 5'd15) begin
      q2_nxt   = q2_est + 21'd1;
      min4_nxt = {4'(r2 - 5'd15), lo3_r};
    end else begin
      q2_nxt   = q2_est;
      min4_nxt = {r2[3:0], lo3_r};
    end

    p3_nxt = {17'd0, q2_r[20:3]} * {18'd0, e2utc_pkg::RECIP_3};

    q3_est = p3_r[33:18];
    q3_x3  = {1'b0, q3_est, 1'b0} + {2'd0, q3_est};
    r3     = xlo5_r - q3_x3[2:0];
    if (r3 >= 3'd3) begin
      days6_nxt = q3_est + 16'd1;
      hr6_nxt   = {2'(r3 - 3'd3), lo5_r};
    end else begin
      days6_nxt = q3_est;
      hr6_nxt   = {r3[1:0], lo5_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    p1_r    <= p1_nxt;
    xlo1_r  <= epoch[6:2];
    lo1_r   <= epoch[1:0];
    rng1_r  <= (epoch < e2utc_pkg::LIMIT_2100);

    q1_r    <= q1_nxt;
    sec2_r  <= sec2_nxt;
    rng2_r  <= rng1_r;

    p2_r    <= p2_nxt;
    xlo3_r  <= q1_r[6:2];
    lo3_r   <= q1_r[1:0];
    sec3_r  <= sec2_r;
    rng3_r  <= rng2_r;

    q2_r    <= q2_nxt;
    min4_r  <= min4_nxt;
    sec4_r  <= sec3_r;
    rng4_r  <= rng3_r;

    p3_r    <= p3_nxt;
    xlo5_r  <= q2_r[5:3];
    lo5_r   <= q2_r[2:0];
    min5_r  <= min4_r;
    sec5_r  <= sec4_r;
    rng5_r  <= rng4_r;

    days6_r <= days6_nxt;
    hr6_r   <= hr6_nxt;
    min6_r  <= min5_r;
    sec6_r  <= sec5_r;
    rng6_r  <= rng5_r;
  end

  assign tod.valid    = v6_r;
  assign tod.days     = days6_r;
  assign tod.hour     = hr6_r;
  assign tod.minute   = min6_r;
  assign tod.second   = sec6_r;
  assign tod.in_range = rng6_r;

endmodule

// ===== src/e2utc_date.sv =====
module e2utc_date (
  input  logic               clk,
  input  logic               rst_n,
  input  e2utc_pkg::tod_t    tod,
  output e2utc_pkg::date_t   date
);

  // Stage 7: estimates for the weekday and the four-year group.
  logic        v7_r;
  logic [29:0] p4_r;
  logic [3:0]  wlo7_r;
  logic [21:0] p5_r;
  logic [11:0] dlo7_r;
  logic [4:0]  hr7_r;
  logic [5:0]  min7_r;
  logic [5:0]  sec7_r;
  logic        rng7_r;

  // Stage 8: weekday, group number and day within the group.
  logic        v8_r;
  logic [2:0]  wd8_r;
  logic [5:0]  quads8_r;
  logic [10:0] dq8_r;
  logic [4:0]  hr8_r;
  logic [5:0]  min8_r;
  logic [5:0]  sec8_r;
  logic        rng8_r;

  // Stage 9: year and day of year.
  logic        v9_r;
  logic [7:0]  year9_r;
  logic [8:0]  doy9_r;
  logic        leap9_r;
  logic [2:0]  wd9_r;
  logic [4:0]  hr9_r;
  logic [5:0]  min9_r;
  logic [5:0]  sec9_r;
  logic        rng9_r;

  // Stage 10: month.
  logic        v10_r;
  logic [3:0]  mon10_r;
  logic [8:0]  doy10_r;
  logic        leap10_r;
  logic [7:0]  year10_r;
  logic [2:0]  wd10_r;
  logic [4:0]  hr10_r;
  logic [5:0]  min10_r;
  logic [5:0]  sec10_r;
  logic        rng10_r;

  // Stage 11: result register.
  logic        v11_r;
  logic [4:0]  dom11_r;
  logic [3:0]  mon11_r;
  logic [7:0]  year11_r;
  logic [2:0]  wd11_r;
  logic [4:0]  hr11_r;
  logic [5:0]  min11_r;
  logic [5:0]  sec11_r;
  logic        rng11_r;

  logic [15:0] wday_in;
  logic [15:0] dgrp_in;
  logic [29:0] p4_nxt;
  logic [21:0] p5_nxt;
  logic [13:0] q7_est;
  logic [16:0] q7_x7;
  logic [3:0]  r7;
  logic [2:0]  wd8_nxt;
  logic [5:0]  qd_est;
  logic [11:0] qd_x1461;
  logic [11:0] rd;
  logic [5:0]  quads8_nxt;
  logic [10:0] dq8_nxt;
  logic [10:0] yrest;
  logic [7:0]  year9_nxt;
  logic [8:0]  doy9_nxt;
  logic        leap9_nxt;
  logic [3:0]  mon10_nxt;
  logic [8:0]  mstart;
  logic [4:0]  dom11_nxt;

  always_comb begin
    wday_in = tod.days + 16'(e2utc_pkg::EPOCH_WEEKDAY);
    dgrp_in = tod.days + 16'(e2utc_pkg::DAYS_1968_1970);
    p4_nxt  = {14'd0, wday_in} * {16'd0, e2utc_pkg::RECIP_7};
    p5_nxt  = {6'd0, dgrp_in} * {16'd0, e2utc_pkg::RECIP_1461};

    q7_est = p4_r[29:16];
    q7_x7  = {q7_est, 3'd0} - {3'd0, q7_est};
    r7     = wlo7_r - q7_x7[3:0];
    if (r7 >= 4'd7) begin
      wd8_nxt = 3'(r7 - 4'd7);
    end else begin
      wd8_nxt = r7[2:0];
    end

    qd_est   = p5_r[21:16];
    qd_x1461 = 12'(qd_est) * 12'(e2utc_pkg::DAYS_PER_QUAD);
    rd       = dlo7_r - qd_x1461;
    if (rd >= 12'(e2utc_pkg::DAYS_PER_QUAD)) begin
      quads8_nxt = qd_est + 6'd1;
      dq8_nxt    = 11'(rd - 12'(e2utc_pkg::DAYS_PER_QUAD));
    end else begin
      quads8_nxt = qd_est;
      dq8_nxt    = rd[10:0];
    end

    // The first year of each group is the leap year; the three after it
    // are normal years.
    yrest     = dq8_r - 11'(e2utc_pkg::DAYS_LEAP_YEAR);
    year9_nxt = e2utc_pkg::BASE_YEAR + {quads8_r, 2'd0};
    leap9_nxt = 1'b0;
    if (dq8_r < 11'(e2utc_pkg::DAYS_LEAP_YEAR)) begin
      leap9_nxt = 1'b1;
      doy9_nxt  = dq8_r[8:0];
    end else if (yrest >= 11'd730) begin
      year9_nxt = year9_nxt + 8'd3;
      doy9_nxt  = 9'(yrest - 11'd730);
    end else if (yrest >= 11'(e2utc_pkg::DAYS_YEAR)) begin
      year9_nxt = year9_nxt + 8'd2;
      doy9_nxt  = 9'(yrest - 11'(e2utc_pkg::DAYS_YEAR));
    end else begin
      year9_nxt = year9_nxt + 8'd1;
      doy9_nxt  = yrest[8:0];
    end

    // Month index is the number of later month starts already reached.
    mon10_nxt = 4'd0;
    for (int i = 1; i < 12; i++) begin
      if (doy9_r >= e2utc_pkg::month_start(leap9_r, 4'(i))) begin
        mon10_nxt = mon10_nxt + 4'd1;
      end
    end

    mstart    = e2utc_pkg::month_start(leap10_r, mon10_r);
    dom11_nxt = 5'(doy10_r - mstart + 9'd1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r  <= 1'b0;
      v8_r  <= 1'b0;
      v9_r  <= 1'b0;
      v10_r <= 1'b0;
      v11_r <= 1'b0;
    end else begin
      v7_r  <= tod.valid;
      v8_r  <= v7_r;
      v9_r  <= v8_r;
      v10_r <= v9_r;
      v11_r <= v10_r;
    end
  end

  always_ff @(posedge clk) begin
    p4_r     <= p4_nxt;
    wlo7_r   <= wday_in[3:0];
    p5_r     <= p5_nxt;
    dlo7_r   <= dgrp_in[11:0];
    hr7_r    <= tod.hour;
    min7_r   <= tod.minute;
    sec7_r   <= tod.second;
    rng7_r   <= tod.in_range;

    wd8_r    <= wd8_nxt;
    quads8_r <= quads8_nxt;
    dq8_r    <= dq8_nxt;
    hr8_r    <= hr7_r;
    min8_r   <= min7_r;
    sec8_r   <= sec7_r;
    rng8_r   <= rng7_r;

    year9_r  <= year9_nxt;
    doy9_r   <= doy9_nxt;
    leap9_r  <= leap9_nxt;
    wd9_r    <= wd8_r;
    hr9_r    <= hr8_r;
    min9_r   <= min8_r;
    sec9_r   <= sec8_r;
    rng9_r   <= rng8_r;

    mon10_r  <= mon10_nxt;
    doy10_r  <= doy9_r;
    leap10_r <= leap9_r;
    year10_r <= year9_r;
    wd10_r   <= wd9_r;
    hr10_r   <= hr9_r;
    min10_r  <= min9_r;
    sec10_r  <= sec9_r;
    rng10_r  <= rng9_r;

    dom11_r  <= dom11_nxt;
    mon11_r  <= mon10_r;
    year11_r <= year10_r;
    wd11_r   <= wd10_r;
    hr11_r   <= hr10_r;
    min11_r  <= min10_r;
    sec11_r  <= sec10_r;
    rng11_r  <= rng10_r;
  end

  assign date.valid            = v11_r;
  assign date.second           = sec11_r;
  assign date.minute           = min11_r;
  assign date.hour             = hr11_r;
  assign date.weekday          = wd11_r;
  assign date.day_of_month     = dom11_r;
  assign date.month            = mon11_r;
  assign date.years_since_1900 = year11_r;
  assign date.in_range         = rng11_r;

endmodule

// ===== src/epoch_seconds_to_utc_date.sv =====
// Converts a 32-bit count of seconds since 1970-01-01 UTC into second, minute,
// hour, weekday, day of month, month and years since 1900. Every fourth year is
// taken as a leap year, so 2100 counts as one; out_in_range is low for inputs
// from 2100-01-01 onward. The block takes one item in every cycle and busy is
// never high. Each result appears on out_valid at the end of the pipeline, for
// one cycle, and cannot be held off. The pipeline holds five divisions by
// constants, each a reciprocal multiply registered and then corrected in the
// next stage, plus the year and month lookup stages.
`include "assert_macros.svh"

module epoch_seconds_to_utc_date (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_epoch_seconds,
  output logic        out_valid,
  output logic [5:0]  out_second,
  output logic [5:0]  out_minute,
  output logic [4:0]  out_hour,
  output logic [2:0]  out_weekday,
  output logic [4:0]  out_day_of_month,
  output logic [3:0]  out_month,
  output logic [7:0]  out_years_since_1900,
  output logic        out_in_range
);

  e2utc_pkg::tod_t  tod;
  e2utc_pkg::date_t date;

  assign busy = 1'b0;

  e2utc_tod u_tod (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (start),
    .epoch    (in_epoch_seconds),
    .tod      (tod)
  );

  e2utc_date u_date (
    .clk   (clk),
    .rst_n (rst_n),
    .tod   (tod),
    .date  (date)
  );

  assign out_valid            = date.valid;
  assign out_second           = date.second;
  assign out_minute           = date.minute;
  assign out_hour             = date.hour;
  assign out_weekday          = date.weekday;
  assign out_day_of_month     = date.day_of_month;
  assign out_month            = date.month;
  assign out_years_since_1900 = date.years_since_1900;
  assign out_in_range         = date.in_range;

  // Every accepted item comes out after the full pipeline depth.
  `ASSERT_CLK(a_item_latency, start |-> ##11 out_valid, "accepted item did not emerge")

  // A February result never runs past day 29.
  `ASSERT_IMPLY(a_feb_days, out_valid && (out_month == 4'd1), out_day_of_month <= 5'd29, "bad February day")

  // A result flagged in range lies before the year 2100.
  `ASSERT_IMPLY(a_range_year, out_valid && out_in_range, out_years_since_1900 <= 8'd199, "in-range year too late")

endmodule

// ===== dv/epoch_seconds_to_utc_date_tb.sv =====
`timescale 1ns / 1ps

module epoch_seconds_to_utc_date_tb;

  localparam int unsigned SECONDS_2100 = 32'd4102444800;
  localparam int unsigned SECONDS_PER_DAY = 86400;
  localparam int unsigned LAST_WHOLE_DAY = 49709;
  localparam int unsigned MONTH_DAYS[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
  localparam int unsigned RANDOM_ITEMS = 530;
  localparam int unsigned DRAIN_CYCLES = 20;

  typedef struct packed {
    logic [5:0] second;
    logic [5:0] minute;
    logic [4:0] hour;
    logic [2:0] weekday;
    logic [4:0] day_of_month;
    logic [3:0] month;
    logic [7:0] years_since_1900;
    logic       in_range;
  } utc_date_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [31:0] in_epoch_seconds = '0;
  logic        out_valid;
  logic [5:0]  out_second;
  logic [5:0]  out_minute;
  logic [4:0]  out_hour;
  logic [2:0]  out_weekday;
  logic [4:0]  out_day_of_month;
  logic [3:0]  out_month;
  logic [7:0]  out_years_since_1900;
  logic        out_in_range;

  utc_date_t   pending_dates[$];
  int unsigned mismatches = 0;
  int unsigned timestamps_sent = 0;
  int unsigned dates_checked = 0;
  int unsigned beyond_2099 = 0;

  epoch_seconds_to_utc_date dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_epoch_seconds     (in_epoch_seconds),
    .out_valid            (out_valid),
    .out_second           (out_second),
    .out_minute           (out_minute),
    .out_hour             (out_hour),
    .out_weekday          (out_weekday),
    .out_day_of_month     (out_day_of_month),
    .out_month            (out_month),
    .out_years_since_1900 (out_years_since_1900),
    .out_in_range         (out_in_range)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Civil date under the four-year rule, counted from 1968 so that every
  // group of four years starts with its leap year.
  function automatic utc_date_t civil_date_of(input logic [31:0] secs);
    utc_date_t   date;
    int unsigned rest;
    int unsigned days;
    int unsigned year;
    int unsigned mon;
    int unsigned mlen;
    bit          leap;
    rest = secs;
    date.second = 6'(rest % 60);
    rest = rest / 60;
    date.minute = 6'(rest % 60);
    rest = rest / 60;
    date.hour = 5'(rest % 24);
    days = rest / 24;
    date.weekday = 3'((days + 4) % 7);
    days = days + 731;
    year = 68 + (days / 1461) * 4;
    days = days % 1461;
    leap = 1'b1;
    if (days > 365) begin
      days = days - 366;
      year = year + 1 + days / 365;
      days = days % 365;
      leap = 1'b0;
    end
    mon = 0;
    mlen = MONTH_DAYS[0];
    while (mon < 11 && days >= mlen) begin
      days = days - mlen;
      mon++;
      mlen = MONTH_DAYS[mon] + ((leap && mon == 1) ? 1 : 0);
    end
    date.day_of_month = 5'(days + 1);
    date.month = 4'(mon);
    date.years_since_1900 = 8'(year);
    date.in_range = (secs < SECONDS_2100);
    return date;
  endfunction

  // Holds start for one timestamp until the block takes it. The gap before the
  // item is drawn here; start only drops when there is a gap to show.
  task automatic send_timestamp(input logic [31:0] secs, input int unsigned max_gap);
    int unsigned gap;
    gap = $urandom_range(max_gap, 0);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_epoch_seconds <= secs;
    do begin
      @(posedge clk);
    end while (busy);
    pending_dates.push_back(civil_date_of(secs));
    timestamps_sent++;
    if (secs >= SECONDS_2100) beyond_2099++;
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    utc_date_t want;
    if (rst_n && out_valid) begin
      if (pending_dates.size() == 0) begin
        $error("result with no timestamp outstanding");
        mismatches++;
      end else begin
        want = pending_dates.pop_front();
        check_field("second", 32'(want.second), 32'(out_second));
        check_field("minute", 32'(want.minute), 32'(out_minute));
        check_field("hour", 32'(want.hour), 32'(out_hour));
        check_field("weekday", 32'(want.weekday), 32'(out_weekday));
        check_field("day_of_month", 32'(want.day_of_month), 32'(out_day_of_month));
        check_field("month", 32'(want.month), 32'(out_month));
        check_field("years_since_1900", 32'(want.years_since_1900),
                    32'(out_years_since_1900));
        check_field("in_range", 32'(want.in_range), 32'(out_in_range));
        dates_checked++;
      end
    end
  end

  task automatic test_field_extremes();
    send_timestamp(32'd0, 5);
    send_timestamp(32'hFFFF_FFFF, 5);
    send_timestamp(32'd59, 5);
    send_timestamp(32'd60, 5);
    send_timestamp(32'd3599, 5);
    send_timestamp(32'd86399, 5);
    send_timestamp(32'd86400, 0);
    send_timestamp(32'h7FFF_FFFF, 0);
    send_timestamp(32'h8000_0000, 0);
    send_timestamp(32'hAAAA_AAAA, 5);
    send_timestamp(32'h5555_5555, 5);
  endtask

  // Year ends and leap days in the first groups and around 2000.
  task automatic test_leap_cycle();
    send_timestamp(32'd63071999, 5);
    send_timestamp(32'd68169600, 5);
    send_timestamp(32'd94694399, 5);
    send_timestamp(32'd126230399, 0);
    send_timestamp(32'd951782400, 0);
    send_timestamp(32'd951868800, 5);
    send_timestamp(32'd978307199, 5);
  endtask

  // 2100 falls under the leap rule, so March onward lands a day early and
  // in_range is low from the first second of the year.
  task automatic test_year_2100();
    send_timestamp(SECONDS_2100 - 1, 5);
    send_timestamp(SECONDS_2100, 0);
    send_timestamp(32'd4107542400, 5);
    send_timestamp(32'd4107628800, 5);
  endtask

  task automatic test_random_timestamps();
    logic [31:0]  secs;
    int unsigned  max_gap;
    for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
      // Every third block of 50 items runs back to back.
      max_gap = ((i / 50) % 3 == 2) ? 0 : 5;
      case ($urandom_range(3, 0))
        0: secs = $urandom;
        1: secs = $urandom_range(SECONDS_2100 - 1, 0);
        2: secs = $urandom_range(LAST_WHOLE_DAY, 0) * SECONDS_PER_DAY
                  + ($urandom_range(1, 0) ? SECONDS_PER_DAY - 1 : 0);
        default: secs = SECONDS_2100 - 32'd34560000 + $urandom_range(32'd69120000, 0);
      endcase
      send_timestamp(secs, max_gap);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_field_extremes();
    test_leap_cycle();
    test_year_2100();
    test_random_timestamps();
    start <= 1'b0;
    while (pending_dates.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("converted %0d timestamps, %0d dates checked, %0d of them past 2099",
             timestamps_sent, dates_checked, beyond_2099);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("timed out with %0d dates outstanding", pending_dates.size());
    $display("tb: failure");
    $finish;
  end

endmodule
